// ===== rtl/fsla_pkg.sv =====
// Shared types and constants for the fixed-slot free-list allocator.
// Used by fsla_ctrl and fixed_slot_free_list_allocator_top; no dependencies.
package fsla_pkg;

  localparam int NUM_SLOTS = 256;
  localparam int SLOT_W    = 8;
  localparam int CNT_W     = 9;
  localparam int ESZ_W     = 13;
  localparam int OFS_W     = 20;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;

  // Request codes
  typedef enum logic [1:0] {
    REQ_ALLOC  = 2'd0,
    REQ_FREE   = 2'd1,
    REQ_REINIT = 2'd2,
    REQ_NOP    = 2'd3
  } req_t;

  // Status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_SIZE = 1'b1;

  // Per-request result handed from the controller to the output stage
  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] grant;
    logic              granted;
    logic [CNT_W-1:0]  free_slots;
  } res_t;

endpackage

// ===== rtl/fixed_slot_free_list_allocator_top.sv =====
// Fixed-slot free-list allocator: handshake, configuration registers, output stage.
// Depends on fsla_pkg and fsla_ctrl.
//
// Usage: each request transaction on the in_ channel (in_tuser = request
// type, in_tdata = slot index for a free) yields exactly one result
// transaction on the out_ channel, carrying status, granted slot, byte offset
// and the free-slot count after the request. Allocate pops the most recently
// freed slot, or else the next never-used slot in ascending order.
// out_tvalid rises in the cycle after acceptance. A request is taken every cycle
// while the output register can take it, except that after an allocate served
// from the freed-slot stack in_tready drops while the new head's link is read
// from the link memory, whose read port is registered. The result sits in an
// output register; a new request is taken while the receiver stalls only if
// that register is empty, otherwise in_tready drops until out_tready frees it.
// The user must write configuration (cfg_addr 0 = slot count, 1 = element size)
// only while the block is idle; the block itself does not enforce this.
// Reset (rst_n low, synchronous) gives a full pool of 256 slots, element size
// 64, and an empty output register; no memory clearing pass is needed.
module fixed_slot_free_list_allocator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] slot_index
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [7:0] granted_slot, [27:8] byte_offset,
                                  // [36:28] free_slots, [39:37] zero
  output logic [1:0]  out_tuser,  // [1:0] status
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_addr,
  input  logic [12:0] cfg_wdata
);
  import fsla_pkg::*;

  logic [CNT_W-1:0]  slot_count_r;
  logic [ESZ_W-1:0]  element_size_r;
  logic              busy;
  logic              accept;
  res_t              res;
  logic              out_valid_r;
  status_t           status_r;
  logic [SLOT_W-1:0] grant_r;
  logic [OFS_W-1:0]  offset_r;
  logic [CNT_W-1:0]  free_slots_r;
  logic [SLOT_W+ESZ_W-1:0] product;

  assign in_tready = !busy && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r   <= CNT_W'(256);
      element_size_r <= ESZ_W'(64);
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_SLOT_COUNT:   slot_count_r   <= cfg_wdata[CNT_W-1:0];
        CFG_ELEMENT_SIZE: element_size_r <= cfg_wdata[ESZ_W-1:0];
        default: begin
        end
      endcase
    end
  end

  fsla_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .req       (req_t'(in_tuser)),
    .idx       (in_tdata),
    .slot_count(slot_count_r),
    .busy      (busy),
    .res       (res)
  );

  // Byte offset of the granted slot
  assign product = res.granted ? (SLOT_W+ESZ_W)'(res.grant) * (SLOT_W+ESZ_W)'(element_size_r)
                               : '0;

  // Output register: load on accept, drop on delivery
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r     <= res.status;
      grant_r      <= res.grant;
      offset_r     <= OFS_W'(product);
      free_slots_r <= res.free_slots;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {3'b000, free_slots_r, offset_r, grant_r};

`ifndef SYNTHESIS
  // Busy from the link fetch after a stack pop clears in the following cycle
  a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("allocator busy for more than one cycle");

  // A failed request grants nothing
  a_fail_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_EMPTY || out_tuser == ST_FULL) |->
      out_tdata[27:0] == 28'd0)
    else $error("grant or offset on a failed request");

  // Free count never exceeds the pool
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[36:28] <= 9'(NUM_SLOTS))
    else $error("free slot count out of range");
`endif

endmodule

// ===== rtl/fsla_link_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Holds the next-slot links of the free stack; no dependencies.
module fsla_link_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/fsla_ctrl.sv =====
// Free-list controller: stack head, prefetched head link, stacked count, fresh counter, free count.
// Depends on fsla_pkg and fsla_link_ram.
module fsla_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  fsla_pkg::req_t        req,
  input  logic [7:0]            idx,
  input  logic [8:0]            slot_count,
  output logic                  busy,
  output fsla_pkg::res_t        res
);
  import fsla_pkg::*;

  logic [SLOT_W-1:0] stack_head_r, stack_head_nxt;
  logic [SLOT_W-1:0] head_link_r, head_link_nxt;
  logic [CNT_W-1:0]  stacked_r, stacked_nxt;
  logic [CNT_W-1:0]  fresh_r, fresh_nxt;
  logic [CNT_W-1:0]  free_r, free_nxt;
  logic              wait_r, wait_nxt;
  logic [CNT_W-1:0]  count;
  logic              do_pop, do_push;
  logic [SLOT_W-1:0] link_rd;

  // Effective pool size
  assign count = (slot_count < CNT_W'(NUM_SLOTS)) ? slot_count : CNT_W'(NUM_SLOTS);

  // Link memory: push writes the old head, pop fetches the link of the new head
  fsla_link_ram #(
    .DEPTH(NUM_SLOTS),
    .WIDTH(SLOT_W)
  ) u_link_ram (
    .clk    (clk),
    .wr_en  (do_push),
    .wr_addr(idx),
    .wr_data(stack_head_r),
    .rd_en  (do_pop),
    .rd_addr(head_link_r),
    .rd_data(link_rd)
  );

  // Decide the request and next state
  always_comb begin
    stack_head_nxt = stack_head_r;
    head_link_nxt  = wait_r ? link_rd : head_link_r;
    stacked_nxt    = stacked_r;
    fresh_nxt      = fresh_r;
    free_nxt       = free_r;
    wait_nxt       = 1'b0;
    do_pop         = 1'b0;
    do_push        = 1'b0;
    res.status     = ST_DONE;
    res.grant      = '0;
    res.granted    = 1'b0;
    if (accept) begin
      unique case (req)
        REQ_ALLOC: begin
          if (free_r != '0 && stacked_r != '0) begin
            do_pop         = 1'b1;
            res.grant      = stack_head_r;
            res.granted    = 1'b1;
            stack_head_nxt = head_link_r;
            stacked_nxt    = stacked_r - 1'b1;
            free_nxt       = free_r - 1'b1;
            wait_nxt       = 1'b1;
          end else if (free_r != '0 && fresh_r < count) begin
            res.grant   = fresh_r[SLOT_W-1:0];
            res.granted = 1'b1;
            fresh_nxt   = fresh_r + 1'b1;
            free_nxt    = free_r - 1'b1;
          end else begin
            res.status = ST_EMPTY;
          end
        end
        REQ_FREE: begin
          if (free_r >= count) begin
            res.status = ST_FULL;
          end else if ({1'b0, idx} < count) begin
            do_push        = 1'b1;
            head_link_nxt  = stack_head_r;
            stack_head_nxt = idx;
            stacked_nxt    = stacked_r + 1'b1;
            free_nxt       = free_r + 1'b1;
          end
        end
        REQ_REINIT: begin
          stack_head_nxt = '0;
          stacked_nxt    = '0;
          fresh_nxt      = '0;
          free_nxt       = count;
        end
        REQ_NOP: begin
        end
        default: begin
        end
      endcase
    end
    res.free_slots = free_nxt;
  end

  // Hold allocator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stack_head_r <= '0;
      head_link_r  <= '0;
      stacked_r    <= '0;
      fresh_r      <= '0;
      free_r       <= CNT_W'(NUM_SLOTS);
      wait_r       <= 1'b0;
    end else begin
      stack_head_r <= stack_head_nxt;
      head_link_r  <= head_link_nxt;
      stacked_r    <= stacked_nxt;
      fresh_r      <= fresh_nxt;
      free_r       <= free_nxt;
      wait_r       <= wait_nxt;
    end
  end

  assign busy = wait_r;

endmodule
